>>> rtl/core/fpag_pkg.sv
// ----------------------------------------------------------------------------
// fpag_pkg
// shared types and constants of the frame peak auto gain block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpag_pkg;

  localparam int GAIN_BITS   = 16;
  localparam int COEFF_BITS  = 9;
  localparam int COEFF_FRAC  = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1 << COEFF_FRAC);
  localparam logic [COEFF_FRAC-1:0] COEFF_HALF = COEFF_FRAC'(1 << (COEFF_FRAC - 1));

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  typedef enum logic [2:0] {
    REG_GAIN_MODE     = 3'd0,
    REG_MANUAL_GAIN   = 3'd1,
    REG_TARGET_PEAK   = 3'd2,
    REG_MIN_GAIN      = 3'd3,
    REG_MAX_GAIN      = 3'd4,
    REG_ATTACK_COEFF  = 3'd5,
    REG_RELEASE_COEFF = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_CLAMP,
    BK_STEP,
    BK_APPLY
  } back_state_t;

  typedef struct packed {
    logic [1:0]            gain_mode;
    logic [GAIN_BITS-1:0]  manual_gain;
    logic [GAIN_BITS-1:0]  target_peak;
    logic [GAIN_BITS-1:0]  min_gain;
    logic [GAIN_BITS-1:0]  max_gain;
    logic [COEFF_BITS-1:0] attack_coeff;
    logic [COEFF_BITS-1:0] release_coeff;
  } cfg_t;

  // lower bound is tested first
  function automatic logic [GAIN_BITS-1:0] clamp_gain(
    input logic [31:0]          g,
    input logic [GAIN_BITS-1:0] lo,
    input logic [GAIN_BITS-1:0] hi
  );
    logic [GAIN_BITS-1:0] r;
    if (g < {{(32-GAIN_BITS){1'b0}}, lo}) begin
      r = lo;
    end else if (g > {{(32-GAIN_BITS){1'b0}}, hi}) begin
      r = hi;
    end else begin
      r = g[GAIN_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/frame_peak_auto_gain_top.sv
// ----------------------------------------------------------------------------
// frame_peak_auto_gain_top
// per-frame peak tracking with attack/release smoothed automatic gain
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  input     | in_valid / in_stall  | first_read, second_read, last_in_frame
//  output    | out_valid / out_stall| centered_sample, gain_valid, frame_gain
//  config    | apb psel/penable     | paddr, pwdata, prdata (7 registers)
//
//  samples inside a frame flow at one item per cycle while out_stall is low and the back part is idle
//  a frame end in automatic mode with a nonzero peak occupies the back part
//  through the pop, the divider (one quotient bit per divider step), then
//  clamp, multiply and apply; with a zero peak it skips the divider and
//  clamp; other frame ends are finished at the pop
//  a four-entry queue lets the front keep taking items while the back divides
//  synchronous active-high reset; in_stall rises only when the queue is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_peak_auto_gain_top #(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input item channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [SAMPLE_BITS-1:0]        first_read,
  input  wire logic [SAMPLE_BITS-1:0]        second_read,
  input  wire logic                          last_in_frame,
  // result item channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [SAMPLE_BITS:0]               centered_sample,
  output logic                               gain_valid,
  output logic [fpag_pkg::GAIN_BITS-1:0]     frame_gain,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [4:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import fpag_pkg::*;

  localparam int EW = 2 * (SAMPLE_BITS + 1) + 1;

  cfg_t          cfg;
  reg_idx_t      reg_idx;
  logic          cfg_wr;
  logic          q_push;
  logic [EW-1:0] q_data;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  logic [EW-1:0] q_head;

  // register file: word addressed, writes complete in the access phase
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_mode     <= MODE_AUTO;
      cfg.manual_gain   <= GAIN_BITS'(256);
      cfg.target_peak   <= GAIN_BITS'(1024);
      cfg.min_gain      <= GAIN_BITS'(26);
      cfg.max_gain      <= GAIN_BITS'(10240);
      cfg.attack_coeff  <= COEFF_BITS'(128);
      cfg.release_coeff <= COEFF_BITS'(13);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN_MODE:     cfg.gain_mode     <= pwdata[1:0];
        REG_MANUAL_GAIN:   cfg.manual_gain   <= pwdata[GAIN_BITS-1:0];
        REG_TARGET_PEAK:   cfg.target_peak   <= pwdata[GAIN_BITS-1:0];
        REG_MIN_GAIN:      cfg.min_gain      <= pwdata[GAIN_BITS-1:0];
        REG_MAX_GAIN:      cfg.max_gain      <= pwdata[GAIN_BITS-1:0];
        REG_ATTACK_COEFF:  cfg.attack_coeff  <= pwdata[COEFF_BITS-1:0];
        REG_RELEASE_COEFF: cfg.release_coeff <= pwdata[COEFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      REG_GAIN_MODE:     prdata = 32'(cfg.gain_mode);
      REG_MANUAL_GAIN:   prdata = 32'(cfg.manual_gain);
      REG_TARGET_PEAK:   prdata = 32'(cfg.target_peak);
      REG_MIN_GAIN:      prdata = 32'(cfg.min_gain);
      REG_MAX_GAIN:      prdata = 32'(cfg.max_gain);
      REG_ATTACK_COEFF:  prdata = 32'(cfg.attack_coeff);
      REG_RELEASE_COEFF: prdata = 32'(cfg.release_coeff);
      default:           prdata = '0;
    endcase
  end

  // front: center, peak tracking, frame end snapshot of the peak
  fpag_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .q_full        (q_full),
    .first_read    (first_read),
    .second_read   (second_read),
    .last_in_frame (last_in_frame),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  assign in_stall = q_full;

  // decoupling queue
  fpag_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  // back: result register, divider and smoothing
  fpag_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_not_empty     (q_not_empty),
    .q_data          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .centered_sample (centered_sample),
    .gain_valid      (gain_valid),
    .frame_gain      (frame_gain)
  );

endmodule

`default_nettype wire

>>> rtl/core/fpag_front.sv
// ----------------------------------------------------------------------------
// fpag_front
// centers each sample, tracks the frame peak and pushes items to the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpag_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       q_full,
  input  wire logic [SAMPLE_BITS-1:0]     first_read,
  input  wire logic [SAMPLE_BITS-1:0]     second_read,
  input  wire logic                       last_in_frame,
  output logic                            q_push,
  output logic [2*(SAMPLE_BITS+1):0]      q_data
);
  import fpag_pkg::*;

  localparam int VW = SAMPLE_BITS + 1;
  localparam logic [VW-1:0] OFFSET = VW'(1) << SAMPLE_BITS;

  logic [VW-1:0] frame_peak;
  logic [VW-1:0] sum;
  logic [VW-1:0] centered;
  logic [VW-1:0] mag;
  logic [VW-1:0] peak_next;

  always_comb begin
    sum       = {1'b0, first_read} + {1'b0, second_read};
    centered  = {~sum[VW-1], sum[VW-2:0]};
    mag       = sum[VW-1] ? (sum - OFFSET) : (OFFSET - sum);
    peak_next = (mag > frame_peak) ? mag : frame_peak;
    q_push    = in_valid && !q_full;
    q_data    = {centered, last_in_frame, peak_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_peak <= '0;
    end else if (q_push) begin
      frame_peak <= last_in_frame ? '0 : peak_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fpag_queue.sv
// ----------------------------------------------------------------------------
// fpag_queue
// short fifo between the front and the back part
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpag_queue #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head_data
);
  import fpag_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full      = (count == CW'(DEPTH));
    not_empty = (count != '0);
    do_push   = push && !full;
    do_pop    = pop && not_empty;
    head_data = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fpag_back.sv
// ----------------------------------------------------------------------------
// fpag_back
// issues results; at an automatic-mode frame end runs the serial divider (nonzero peak) and gain smoothing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpag_back #(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fpag_pkg::cfg_t                cfg,
  input  wire logic                          q_not_empty,
  input  wire logic [2*(SAMPLE_BITS+1):0]    q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [SAMPLE_BITS:0]               centered_sample,
  output logic                               gain_valid,
  output logic [fpag_pkg::GAIN_BITS-1:0]     frame_gain
);
  import fpag_pkg::*;

  localparam int VW  = SAMPLE_BITS + 1;
  localparam int DW  = GAIN_BITS + 1 + GAIN_FRAC_BITS;
  localparam int CNW = $clog2(DW);
  localparam int PRW = COEFF_BITS + GAIN_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;

  back_state_t state, state_next;

  logic [VW-1:0]        hold_c, hold_c_next;
  logic [DW-1:0]        dq, dq_next;
  logic [VW-1:0]        rem, rem_next;
  logic [VW-1:0]        div, div_next;
  logic [CNW-1:0]       cnt, cnt_next;
  logic [GAIN_BITS-1:0] tgt, tgt_next;
  logic [PRW-1:0]       prod, prod_next;
  logic                 dir, dir_next;
  logic [GAIN_BITS-1:0] sg, sg_next;
  logic                 out_valid_next;
  logic [VW-1:0]        centered_next;
  logic                 gain_valid_next;
  logic [GAIN_BITS-1:0] frame_gain_next;

  logic [VW-1:0]        q_c;
  logic                 q_last;
  logic [VW-1:0]        q_peak;
  logic                 slot_free;
  logic [VW:0]          trial;
  logic                 fits;
  logic [COEFF_BITS-1:0] coeff;
  logic [GAIN_BITS-1:0] diff;
  logic [PRW:0]         rounded;
  logic [GAIN_BITS:0]   step_mag;
  logic [GAIN_BITS:0]   sum_next;

  always_comb begin
    {q_c, q_last, q_peak} = q_data;
    slot_free = !out_valid || !out_stall;

    trial = {rem, dq[DW-1]};
    fits  = (trial >= {1'b0, div});

    // attack when the target is below the smoothed gain, release otherwise
    if (tgt < sg) begin
      coeff = cfg.attack_coeff;
      diff  = sg - tgt;
    end else begin
      coeff = cfg.release_coeff;
      diff  = tgt - sg;
    end
    if (coeff > COEFF_ONE) begin
      coeff = COEFF_ONE;
    end

    rounded  = {1'b0, prod} + (PRW+1)'(COEFF_HALF);
    step_mag = rounded[COEFF_FRAC +: GAIN_BITS+1];
    sum_next = dir ? ({1'b0, sg} - step_mag) : ({1'b0, sg} + step_mag);

    state_next      = state;
    hold_c_next     = hold_c;
    dq_next         = dq;
    rem_next        = rem;
    div_next        = div;
    cnt_next        = cnt;
    tgt_next        = tgt;
    prod_next       = prod;
    dir_next        = dir;
    sg_next         = sg;
    out_valid_next  = out_valid && out_stall;
    centered_next   = centered_sample;
    gain_valid_next = gain_valid;
    frame_gain_next = frame_gain;
    q_pop           = 1'b0;

    unique case (state)
      BK_IDLE: begin
        if (q_not_empty && slot_free) begin
          q_pop = 1'b1;
          if (!q_last) begin
            out_valid_next  = 1'b1;
            centered_next   = q_c;
            gain_valid_next = 1'b0;
            frame_gain_next = '0;
          end else begin
            unique case (cfg.gain_mode)
              MODE_MANUAL: begin
                out_valid_next  = 1'b1;
                centered_next   = q_c;
                gain_valid_next = 1'b1;
                frame_gain_next = cfg.manual_gain;
              end
              MODE_AUTO: begin
                hold_c_next = q_c;
                if (q_peak == '0) begin
                  tgt_next   = GAIN_ONE;
                  state_next = BK_STEP;
                end else begin
                  dq_next    = {cfg.target_peak, 1'b0, {GAIN_FRAC_BITS{1'b0}}};
                  rem_next   = '0;
                  div_next   = q_peak;
                  cnt_next   = '0;
                  state_next = BK_DIV;
                end
              end
              default: begin
                out_valid_next  = 1'b1;
                centered_next   = q_c;
                gain_valid_next = 1'b1;
                frame_gain_next = '0;
              end
            endcase
          end
        end
      end
      BK_DIV: begin
        rem_next = fits ? VW'(trial - {1'b0, div}) : trial[VW-1:0];
        dq_next  = {dq[DW-2:0], fits};
        cnt_next = cnt + CNW'(1);
        if (cnt == CNW'(DW - 1)) begin
          state_next = BK_CLAMP;
        end
      end
      BK_CLAMP: begin
        tgt_next   = clamp_gain(32'(dq), cfg.min_gain, cfg.max_gain);
        state_next = BK_STEP;
      end
      BK_STEP: begin
        prod_next  = PRW'(coeff * diff);
        dir_next   = (tgt < sg);
        state_next = BK_APPLY;
      end
      BK_APPLY: begin
        if (slot_free) begin
          sg_next         = clamp_gain(32'(sum_next), cfg.min_gain, cfg.max_gain);
          out_valid_next  = 1'b1;
          centered_next   = hold_c;
          gain_valid_next = 1'b1;
          frame_gain_next = sg_next;
          state_next      = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      sg        <= GAIN_ONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sg        <= sg_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_c          <= hold_c_next;
    dq              <= dq_next;
    rem             <= rem_next;
    div             <= div_next;
    cnt             <= cnt_next;
    tgt             <= tgt_next;
    prod            <= prod_next;
    dir             <= dir_next;
    centered_sample <= centered_next;
    gain_valid      <= gain_valid_next;
    frame_gain      <= frame_gain_next;
  end

endmodule

`default_nettype wire
